FILE: hdl/tle_pkg.sv
package tle_pkg;

   localparam int BYTE_W    = 8;
   localparam int ACTION_W  = 3;
   localparam int COUNT_W   = 6;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 24;
   localparam int RSP_PAD_W = RSP_W - ACTION_W - BYTE_W - COUNT_W;
   localparam int REG_IDX_W = 1;

   localparam logic [REG_IDX_W-1:0] REG_ERASE_CHAR = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_KILL_CHAR  = 1'd1;

   localparam logic [BYTE_W-1:0] ERASE_CHAR_RESET = 8'd127;
   localparam logic [BYTE_W-1:0] KILL_CHAR_RESET  = 8'd21;

   localparam logic [BYTE_W-1:0] CODE_EOT    = 8'h04;
   localparam logic [BYTE_W-1:0] CODE_BELL   = 8'h07;
   localparam logic [BYTE_W-1:0] CODE_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CODE_NL     = 8'h0A;
   localparam logic [BYTE_W-1:0] CODE_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CODE_WERASE = 8'h17;
   localparam logic [BYTE_W-1:0] CODE_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CODE_TILDE  = 8'h7E;

   typedef enum logic [ACTION_W-1:0] {
      ACTION_ECHO    = 3'd0,
      ACTION_ERASE   = 3'd1,
      ACTION_NEWLINE = 3'd2,
      ACTION_BELL    = 3'd3,
      ACTION_EOI     = 3'd4
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EMIT_EOT,
      ST_EMIT_ERASE1,
      ST_EMIT_KILL,
      ST_EMIT_NL,
      ST_EMIT_BELL,
      ST_EMIT_ECHO,
      ST_WERASE_PRIME,
      ST_WALK_WERASE,
      ST_EMIT_WERASE,
      ST_WRAP_PRIME,
      ST_WALK_WRAP,
      ST_WRAP_NL,
      ST_WRAP_ERASE,
      ST_WRAP_MOVE_NL,
      ST_COPY
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_DEC,
      CUR_ZERO,
      CUR_INC,
      CUR_PTR,
      CUR_MOVED
   } cur_op_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_LOAD_SPACE,
      PTR_LOAD_WORD,
      PTR_WALK
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_WALK,
      RD_COPY,
      RD_COPY_NEXT
   } rd_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_CH,
      WR_COPY
   } wr_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_STEP
   } idx_op_type;

   typedef enum logic [2:0] {
      OUT_EOT,
      OUT_ERASE_ONE,
      OUT_ERASE_CUR,
      OUT_ERASE_MOVED,
      OUT_NL,
      OUT_BELL,
      OUT_ECHO_CH,
      OUT_ECHO_RD
   } out_sel_type;

   typedef struct packed {
      logic        load_ch;
      logic        set_finished;
      cur_op_type  cur_op;
      ptr_op_type  ptr_op;
      rd_op_type   rd_op;
      wr_op_type   wr_op;
      idx_op_type  idx_op;
      logic        emit;
      out_sel_type out_sel;
      logic        last;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
      logic ch_eot;
      logic ch_erase;
      logic ch_kill;
      logic ch_werase;
      logic ch_nl;
      logic ch_print;
      logic ch_space;
      logic cursor_zero;
      logic cursor_last_col;
      logic walk_done;
      logic ptr_zero;
      logic copy_last;
      logic out_free;
   } dp_status_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      return (c == CODE_SPACE) || (c >= CODE_TAB && c <= CODE_CR);
   endfunction

   function automatic logic is_print(input logic [BYTE_W-1:0] c);
      return (c >= CODE_SPACE) && (c <= CODE_TILDE);
   endfunction

endpackage

FILE: hdl/tle_datapath.sv
module tle_datapath #(
   parameter int LINE_WIDTH = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tle_pkg::REQ_W-1:0]         req_tdata,
   input  logic                              csr_we,
   input  logic [tle_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [tle_pkg::BYTE_W-1:0]        csr_wdata,
   input  tle_pkg::dp_cmd_type               cmd,
   output tle_pkg::dp_status_type            status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tle_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int CW      = $clog2(LINE_WIDTH + 1);
   localparam int AW      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam int BYTE_W  = tle_pkg::BYTE_W;
   localparam int COUNT_W = tle_pkg::COUNT_W;

   logic [BYTE_W-1:0] line_mem [LINE_WIDTH];

   logic [BYTE_W-1:0] erase_ff, erase_in;
   logic [BYTE_W-1:0] kill_ff, kill_in;
   logic [BYTE_W-1:0] ch_ff, ch_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              phase_word_ff, phase_word_in;
   logic              finished_ff, finished_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [tle_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CW-1:0]     moved;
   logic              rd_space;
   logic              walk_step;
   logic [CW-1:0]     rd_addr_full;
   logic [CW-1:0]     wr_addr_full;
   logic [BYTE_W-1:0] wr_data;
   tle_pkg::action_type        out_action;
   logic [BYTE_W-1:0]          out_byte;
   logic [COUNT_W-1:0]         out_count;

   assign moved     = cursor_ff - ptr_ff;
   assign rd_space  = tle_pkg::is_space(rd_data_ff);
   assign walk_step = (ptr_ff != '0) && (phase_word_ff ? !rd_space : rd_space);

   always_comb begin
      status.finished        = finished_ff;
      status.ch_eot          = (ch_ff == tle_pkg::CODE_EOT);
      status.ch_erase        = (ch_ff == erase_ff);
      status.ch_kill         = (ch_ff == kill_ff);
      status.ch_werase       = (ch_ff == tle_pkg::CODE_WERASE);
      status.ch_nl           = (ch_ff == tle_pkg::CODE_NL);
      status.ch_print        = tle_pkg::is_print(ch_ff);
      status.ch_space        = tle_pkg::is_space(ch_ff);
      status.cursor_zero     = (cursor_ff == '0);
      status.cursor_last_col = (cursor_ff == CW'(LINE_WIDTH - 1));
      status.walk_done       = phase_word_ff && !walk_step;
      status.ptr_zero        = (ptr_ff == '0);
      status.copy_last       = ((idx_ff + CW'(1)) == moved);
      status.out_free        = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      erase_in = erase_ff;
      kill_in  = kill_ff;
      if (csr_we) begin
         case (csr_index)
            tle_pkg::REG_ERASE_CHAR: erase_in = csr_wdata;
            tle_pkg::REG_KILL_CHAR:  kill_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign ch_in       = cmd.load_ch ? req_tdata[BYTE_W-1:0] : ch_ff;
   assign finished_in = finished_ff | cmd.set_finished;

   always_comb begin
      case (cmd.cur_op)
         tle_pkg::CUR_DEC:   cursor_in = cursor_ff - CW'(1);
         tle_pkg::CUR_ZERO:  cursor_in = '0;
         tle_pkg::CUR_INC:   cursor_in = cursor_ff + CW'(1);
         tle_pkg::CUR_PTR:   cursor_in = ptr_ff;
         tle_pkg::CUR_MOVED: cursor_in = moved;
         default:            cursor_in = cursor_ff;
      endcase
   end

   always_comb begin
      ptr_in        = ptr_ff;
      phase_word_in = phase_word_ff;
      case (cmd.ptr_op)
         tle_pkg::PTR_LOAD_SPACE: begin
            ptr_in        = cursor_ff;
            phase_word_in = 1'b0;
         end
         tle_pkg::PTR_LOAD_WORD: begin
            ptr_in        = cursor_ff;
            phase_word_in = 1'b1;
         end
         tle_pkg::PTR_WALK: begin
            if (walk_step) begin
               ptr_in = ptr_ff - CW'(1);
            end else begin
               phase_word_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.idx_op)
         tle_pkg::IDX_CLEAR: idx_in = '0;
         tle_pkg::IDX_STEP:  idx_in = idx_ff + CW'(1);
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_op)
         tle_pkg::RD_WALK:      rd_addr_full = walk_step ? ptr_ff - CW'(2) : ptr_ff - CW'(1);
         tle_pkg::RD_COPY:      rd_addr_full = ptr_ff + idx_ff;
         tle_pkg::RD_COPY_NEXT: rd_addr_full = ptr_ff + idx_ff + CW'(1);
         default:               rd_addr_full = cursor_ff - CW'(1);
      endcase
   end

   assign wr_addr_full = (cmd.wr_op == tle_pkg::WR_CH) ? cursor_ff : idx_ff;
   assign wr_data      = (cmd.wr_op == tle_pkg::WR_CH) ? ch_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_op != tle_pkg::WR_NONE) begin
         line_mem[wr_addr_full[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= line_mem[rd_addr_full[AW-1:0]];
   end

   always_comb begin
      out_action = tle_pkg::ACTION_ECHO;
      out_byte   = '0;
      out_count  = '0;
      case (cmd.out_sel)
         tle_pkg::OUT_EOT: out_action = tle_pkg::ACTION_EOI;
         tle_pkg::OUT_ERASE_ONE: begin
            out_action = tle_pkg::ACTION_ERASE;
            out_count  = COUNT_W'(1);
         end
         tle_pkg::OUT_ERASE_CUR: begin
            out_action = tle_pkg::ACTION_ERASE;
            out_count  = COUNT_W'(cursor_ff);
         end
         tle_pkg::OUT_ERASE_MOVED: begin
            out_action = tle_pkg::ACTION_ERASE;
            out_count  = COUNT_W'(moved);
         end
         tle_pkg::OUT_NL: begin
            out_action = tle_pkg::ACTION_NEWLINE;
            out_byte   = tle_pkg::CODE_NL;
         end
         tle_pkg::OUT_BELL: begin
            out_action = tle_pkg::ACTION_BELL;
            out_byte   = tle_pkg::CODE_BELL;
         end
         tle_pkg::OUT_ECHO_CH: out_byte = ch_ff;
         tle_pkg::OUT_ECHO_RD: out_byte = rd_data_ff;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{tle_pkg::RSP_PAD_W{1'b0}}, out_count, out_byte, out_action};
         rsp_last_in  = cmd.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_ff      <= tle_pkg::ERASE_CHAR_RESET;
         kill_ff       <= tle_pkg::KILL_CHAR_RESET;
         cursor_ff     <= '0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_word_ff <= 1'b0;
      end else begin
         erase_ff      <= erase_in;
         kill_ff       <= kill_in;
         cursor_ff     <= cursor_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_word_ff <= phase_word_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/tle_controller.sv
module tle_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tle_pkg::dp_status_type status,
   output tle_pkg::dp_cmd_type    cmd
);

   tle_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tle_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tle_pkg::ST_DISPATCH;
         end
         tle_pkg::ST_DISPATCH: begin
            if (status.finished) begin
               state_in = tle_pkg::ST_IDLE;
            end else if (status.ch_eot && status.cursor_zero) begin
               state_in = tle_pkg::ST_EMIT_EOT;
            end else if (status.ch_erase && !status.cursor_zero) begin
               state_in = tle_pkg::ST_EMIT_ERASE1;
            end else if (status.ch_kill) begin
               state_in = tle_pkg::ST_EMIT_KILL;
            end else if (status.ch_werase) begin
               state_in = tle_pkg::ST_WERASE_PRIME;
            end else if (status.ch_nl) begin
               state_in = tle_pkg::ST_EMIT_NL;
            end else if (!status.ch_print) begin
               state_in = tle_pkg::ST_EMIT_BELL;
            end else begin
               state_in = tle_pkg::ST_EMIT_ECHO;
            end
         end
         tle_pkg::ST_EMIT_EOT, tle_pkg::ST_EMIT_ERASE1, tle_pkg::ST_EMIT_KILL,
         tle_pkg::ST_EMIT_NL, tle_pkg::ST_EMIT_BELL, tle_pkg::ST_EMIT_WERASE,
         tle_pkg::ST_WRAP_NL: begin
            if (status.out_free) state_in = tle_pkg::ST_IDLE;
         end
         tle_pkg::ST_EMIT_ECHO: begin
            if (status.out_free) begin
               if (!status.cursor_last_col) begin
                  state_in = tle_pkg::ST_IDLE;
               end else if (status.ch_space) begin
                  state_in = tle_pkg::ST_WRAP_NL;
               end else begin
                  state_in = tle_pkg::ST_WRAP_PRIME;
               end
            end
         end
         tle_pkg::ST_WERASE_PRIME: state_in = tle_pkg::ST_WALK_WERASE;
         tle_pkg::ST_WALK_WERASE: begin
            if (status.walk_done) state_in = tle_pkg::ST_EMIT_WERASE;
         end
         tle_pkg::ST_WRAP_PRIME: state_in = tle_pkg::ST_WALK_WRAP;
         tle_pkg::ST_WALK_WRAP: begin
            if (status.walk_done) begin
               state_in = status.ptr_zero ? tle_pkg::ST_WRAP_NL : tle_pkg::ST_WRAP_ERASE;
            end
         end
         tle_pkg::ST_WRAP_ERASE: begin
            if (status.out_free) state_in = tle_pkg::ST_WRAP_MOVE_NL;
         end
         tle_pkg::ST_WRAP_MOVE_NL: begin
            if (status.out_free) state_in = tle_pkg::ST_COPY;
         end
         tle_pkg::ST_COPY: begin
            if (status.out_free && status.copy_last) state_in = tle_pkg::ST_IDLE;
         end
         default: state_in = tle_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready       = 1'b0;
      cmd.load_ch      = 1'b0;
      cmd.set_finished = 1'b0;
      cmd.cur_op       = tle_pkg::CUR_HOLD;
      cmd.ptr_op       = tle_pkg::PTR_HOLD;
      cmd.rd_op        = tle_pkg::RD_CUR;
      cmd.wr_op        = tle_pkg::WR_NONE;
      cmd.idx_op       = tle_pkg::IDX_HOLD;
      cmd.emit         = 1'b0;
      cmd.out_sel      = tle_pkg::OUT_NL;
      cmd.last         = 1'b1;
      case (state_ff)
         tle_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_ch = req_tvalid;
         end
         tle_pkg::ST_EMIT_EOT: begin
            cmd.out_sel      = tle_pkg::OUT_EOT;
            cmd.emit         = status.out_free;
            cmd.set_finished = status.out_free;
         end
         tle_pkg::ST_EMIT_ERASE1: begin
            cmd.out_sel = tle_pkg::OUT_ERASE_ONE;
            cmd.emit    = status.out_free;
            if (status.out_free) cmd.cur_op = tle_pkg::CUR_DEC;
         end
         tle_pkg::ST_EMIT_KILL: begin
            cmd.out_sel = tle_pkg::OUT_ERASE_CUR;
            cmd.emit    = status.out_free;
            if (status.out_free) cmd.cur_op = tle_pkg::CUR_ZERO;
         end
         tle_pkg::ST_EMIT_NL, tle_pkg::ST_WRAP_NL: begin
            cmd.out_sel = tle_pkg::OUT_NL;
            cmd.emit    = status.out_free;
            if (status.out_free) cmd.cur_op = tle_pkg::CUR_ZERO;
         end
         tle_pkg::ST_EMIT_BELL: begin
            cmd.out_sel = tle_pkg::OUT_BELL;
            cmd.emit    = status.out_free;
         end
         tle_pkg::ST_EMIT_ECHO: begin
            cmd.out_sel = tle_pkg::OUT_ECHO_CH;
            cmd.last    = !status.cursor_last_col;
            cmd.emit    = status.out_free;
            if (status.out_free) begin
               cmd.cur_op = tle_pkg::CUR_INC;
               cmd.wr_op  = tle_pkg::WR_CH;
            end
         end
         tle_pkg::ST_WERASE_PRIME: cmd.ptr_op = tle_pkg::PTR_LOAD_SPACE;
         tle_pkg::ST_WRAP_PRIME:   cmd.ptr_op = tle_pkg::PTR_LOAD_WORD;
         tle_pkg::ST_WALK_WERASE, tle_pkg::ST_WALK_WRAP: begin
            cmd.ptr_op = tle_pkg::PTR_WALK;
            cmd.rd_op  = tle_pkg::RD_WALK;
         end
         tle_pkg::ST_EMIT_WERASE: begin
            cmd.out_sel = tle_pkg::OUT_ERASE_MOVED;
            cmd.emit    = status.out_free;
            if (status.out_free) cmd.cur_op = tle_pkg::CUR_PTR;
         end
         tle_pkg::ST_WRAP_ERASE: begin
            cmd.out_sel = tle_pkg::OUT_ERASE_MOVED;
            cmd.last    = 1'b0;
            cmd.emit    = status.out_free;
            if (status.out_free) cmd.idx_op = tle_pkg::IDX_CLEAR;
         end
         tle_pkg::ST_WRAP_MOVE_NL: begin
            cmd.out_sel = tle_pkg::OUT_NL;
            cmd.last    = 1'b0;
            cmd.rd_op   = tle_pkg::RD_COPY;
            cmd.emit    = status.out_free;
         end
         tle_pkg::ST_COPY: begin
            cmd.out_sel = tle_pkg::OUT_ECHO_RD;
            cmd.last    = status.copy_last;
            cmd.emit    = status.out_free;
            cmd.rd_op   = status.out_free ? tle_pkg::RD_COPY_NEXT : tle_pkg::RD_COPY;
            if (status.out_free) begin
               cmd.wr_op  = tle_pkg::WR_COPY;
               cmd.idx_op = tle_pkg::IDX_STEP;
               if (status.copy_last) cmd.cur_op = tle_pkg::CUR_MOVED;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/terminal_line_editor.sv
// Each result item is registered before it is offered. A new byte is taken only once every
// result item of the last byte is in the output register, so output stalls hold the input; a
// byte after end of input gives no result. Word erase and a line wrap first walk the line
// store back, and a wrap that moves a word then copies it to the start of the line.
// Reset is synchronous: it clears the cursor and the end-of-input flag and restores the erase
// and kill codes to 127 and 21; the line store is not cleared.
module terminal_line_editor #(
   parameter int LINE_WIDTH = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tle_pkg::REQ_W-1:0]     req_tdata,   // typed_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tle_pkg::RSP_W-1:0]     rsp_tdata,   // action, echo_byte, erase_count
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [tle_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [tle_pkg::BYTE_W-1:0]    csr_wdata
);

   tle_pkg::dp_cmd_type    cmd;
   tle_pkg::dp_status_type status;

   tle_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tle_datapath #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result item loaded over one still waiting");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item accepted while one is in work");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      status.finished |=> status.finished)
      else $error("end-of-input flag dropped");

   a_move_ends_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.cur_op == tle_pkg::CUR_MOVED) |-> (cmd.emit && cmd.last))
      else $error("wrap finished without the item's final result");

endmodule

FILE: verif/terminal_line_editor_checker.sv
module terminal_line_editor_checker #(
   parameter int LINE_WIDTH = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [tle_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [tle_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [tle_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [tle_pkg::BYTE_W-1:0]    csr_wdata,
   output int                            fault_count,
   output int                            outstanding
);

   localparam int BYTE_W   = tle_pkg::BYTE_W;
   localparam int COUNT_W  = tle_pkg::COUNT_W;
   localparam int ACTION_W = tle_pkg::ACTION_W;

   typedef struct packed {
      tle_pkg::action_type action;
      logic [BYTE_W-1:0]   shown;
      logic [COUNT_W-1:0]  columns;
      logic                last;
   } display_item_type;

   display_item_type display_queue[$];
   display_item_type step_items[0:LINE_WIDTH+7];
   int step_count;

   logic [BYTE_W-1:0] line_text[0:LINE_WIDTH-1];
   int column;
   logic at_end;
   logic [BYTE_W-1:0] erase_code;
   logic [BYTE_W-1:0] kill_code;

   initial begin
      fault_count = 0;
      outstanding = 0;
      step_count = 0;
   end

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return c == tle_pkg::CODE_SPACE || (c >= tle_pkg::CODE_TAB && c <= tle_pkg::CODE_CR);
   endfunction

   function automatic logic is_visible(input logic [BYTE_W-1:0] c);
      return c >= tle_pkg::CODE_SPACE && c <= tle_pkg::CODE_TILDE;
   endfunction

   task automatic note(input tle_pkg::action_type a, input logic [BYTE_W-1:0] s,
                       input int cols);
      display_item_type item;
      item.action = a;
      item.shown = s;
      item.columns = cols[COUNT_W-1:0];
      item.last = 1'b0;
      step_items[step_count] = item;
      step_count++;
   endtask

   task automatic edit_line(input logic [BYTE_W-1:0] ch);
      int first;
      int sp;
      int moved;
      int i;
      display_item_type item;
      step_count = 0;
      if (!at_end) begin
         if (ch == tle_pkg::CODE_EOT && column == 0) begin
            at_end = 1'b1;
            note(tle_pkg::ACTION_EOI, 8'h00, 0);
         end else if (ch == erase_code && column > 0) begin
            column--;
            note(tle_pkg::ACTION_ERASE, 8'h00, 1);
         end else if (ch == kill_code) begin
            note(tle_pkg::ACTION_ERASE, 8'h00, column);
            column = 0;
         end else if (ch == tle_pkg::CODE_WERASE) begin
            first = column;
            while (column > 0 && is_blank(line_text[column-1])) column--;
            while (column > 0 && !is_blank(line_text[column-1])) column--;
            note(tle_pkg::ACTION_ERASE, 8'h00, first - column);
         end else if (ch == tle_pkg::CODE_NL) begin
            column = 0;
            note(tle_pkg::ACTION_NEWLINE, tle_pkg::CODE_NL, 0);
         end else if (!is_visible(ch)) begin
            note(tle_pkg::ACTION_BELL, tle_pkg::CODE_BELL, 0);
         end else begin
            note(tle_pkg::ACTION_ECHO, ch, 0);
            if (column < LINE_WIDTH) begin
               line_text[column] = ch;
               column++;
            end
            if (column >= LINE_WIDTH) begin
               // A full line carries its last word, if it has one, over to a new line.
               sp = column;
               if (!is_blank(ch)) begin
                  while (sp > 0 && !is_blank(line_text[sp-1])) sp--;
               end else begin
                  sp = 0;
               end
               if (sp > 0) begin
                  moved = column - sp;
                  note(tle_pkg::ACTION_ERASE, 8'h00, moved);
                  for (i = 0; i < moved; i++) line_text[i] = line_text[sp+i];
                  note(tle_pkg::ACTION_NEWLINE, tle_pkg::CODE_NL, 0);
                  for (i = 0; i < moved; i++) note(tle_pkg::ACTION_ECHO, line_text[i], 0);
                  column = moved;
               end else begin
                  note(tle_pkg::ACTION_NEWLINE, tle_pkg::CODE_NL, 0);
                  column = 0;
               end
            end
         end
      end
      for (i = 0; i < step_count; i++) begin
         item = step_items[i];
         item.last = (i == step_count - 1);
         display_queue.push_back(item);
      end
   endtask

   task automatic compare_display();
      display_item_type want;
      logic [ACTION_W-1:0] got_action;
      logic [BYTE_W-1:0] got_shown;
      logic [COUNT_W-1:0] got_columns;
      got_action = rsp_tdata[ACTION_W-1:0];
      got_shown = rsp_tdata[ACTION_W +: BYTE_W];
      got_columns = rsp_tdata[ACTION_W+BYTE_W +: COUNT_W];
      if (display_queue.size() == 0) begin
         $error("unexpected result item: action %0d, echo_byte 0x%02h, erase_count %0d",
                got_action, got_shown, got_columns);
         fault_count++;
      end else begin
         want = display_queue.pop_front();
         if (got_action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got_action);
            fault_count++;
         end
         if (got_shown !== want.shown) begin
            $error("echo_byte: expected 0x%02h, actual 0x%02h", want.shown, got_shown);
            fault_count++;
         end
         if (got_columns !== want.columns) begin
            $error("erase_count: expected %0d, actual %0d", want.columns, got_columns);
            fault_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
            fault_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         column = 0;
         at_end = 1'b0;
         erase_code = tle_pkg::ERASE_CHAR_RESET;
         kill_code = tle_pkg::KILL_CHAR_RESET;
         display_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               tle_pkg::REG_ERASE_CHAR: erase_code = csr_wdata;
               tle_pkg::REG_KILL_CHAR:  kill_code = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) compare_display();
         if (req_tvalid && req_tready) edit_line(req_tdata);
      end
      outstanding = display_queue.size();
   end

endmodule

FILE: verif/terminal_line_editor_tb.sv
module terminal_line_editor_tb;

   localparam int LINE_WIDTH    = 40;
   localparam int BYTE_W        = tle_pkg::BYTE_W;
   localparam int SETTLE_CYCLES = 2 * LINE_WIDTH + 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 18;
   localparam int HOLD_AFTER    = 6;
   localparam int PAUSE_AFTER   = 9;
   localparam int CYCLE_LIMIT   = 400000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tle_pkg::REQ_W-1:0]     req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tle_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we = 1'b0;
   logic [tle_pkg::REG_IDX_W-1:0] csr_index = tle_pkg::REG_ERASE_CHAR;
   logic [BYTE_W-1:0]             csr_wdata = '0;

   int fault_count;
   int outstanding;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   logic [BYTE_W-1:0] erase_code = tle_pkg::ERASE_CHAR_RESET;
   logic [BYTE_W-1:0] kill_code = tle_pkg::KILL_CHAR_RESET;

   always #2 clock = ~clock;

   terminal_line_editor #(
      .LINE_WIDTH(LINE_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   terminal_line_editor_checker #(
      .LINE_WIDTH(LINE_WIDTH)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   // A change of hold_toggle starts a long stretch in which no result item is taken.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      logic ready_seen;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_for_display();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_codes(input logic [BYTE_W-1:0] e, input logic [BYTE_W-1:0] k);
      csr_we <= 1'b1;
      csr_index <= tle_pkg::REG_ERASE_CHAR;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= tle_pkg::REG_KILL_CHAR;
      csr_wdata <= k;
      @(posedge clock);
      csr_we <= 1'b0;
      erase_code = e;
      kill_code = k;
   endtask

   // Mostly words and spaces, so that lines fill and wrap, with editing codes and noise.
   task automatic send_token();
      int pick;
      int len;
      logic [BYTE_W-1:0] noise;
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 44) : $urandom_range(1, 7);
         repeat (len) send_byte(BYTE_W'($urandom_range(33, 126)));
         if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(1, 2)) send_byte(tle_pkg::CODE_SPACE);
         end
      end else if (pick < 70) begin
         send_byte(erase_code);
      end else if (pick < 73) begin
         send_byte(kill_code);
      end else if (pick < 79) begin
         send_byte(tle_pkg::CODE_WERASE);
      end else if (pick < 82) begin
         send_byte(tle_pkg::CODE_NL);
      end else if (pick < 85) begin
         send_byte(8'h61);
         send_byte(tle_pkg::CODE_EOT);
      end else if (pick < 90) begin
         send_byte(BYTE_W'($urandom_range(tle_pkg::CODE_TAB, tle_pkg::CODE_CR)));
      end else begin
         noise = BYTE_W'($urandom_range(0, 255));
         if (noise == tle_pkg::CODE_EOT) noise = 8'h05;
         send_byte(noise);
      end
   endtask

   initial begin
      int phase;
      int phase_start;
      logic held;
      logic paused;
      logic [BYTE_W-1:0] e;
      logic [BYTE_W-1:0] k;
      held = 1'b0;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(tle_pkg::ERASE_CHAR_RESET);
      send_byte(tle_pkg::KILL_CHAR_RESET);
      send_byte(tle_pkg::CODE_WERASE);
      send_text("ab c");
      send_byte(tle_pkg::CODE_EOT);
      send_byte(tle_pkg::ERASE_CHAR_RESET);
      send_byte(tle_pkg::CODE_WERASE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(tle_pkg::CODE_TAB);
      send_byte(8'h1F);
      send_text("~ !");
      send_byte(tle_pkg::KILL_CHAR_RESET);
      send_text("x");
      send_byte(tle_pkg::CODE_NL);

      for (phase = 0; phase < 4; phase++) begin
         wait_for_display();
         case (phase)
            0: begin
               e = tle_pkg::ERASE_CHAR_RESET; k = tle_pkg::KILL_CHAR_RESET;
               idle_pct = 0; stall_pct <= 0;
            end
            1: begin e = 8'h00; k = 8'hFF; idle_pct = 50; stall_pct <= 0;  end
            2: begin e = 8'hFF; k = 8'h00; idle_pct = 0;  stall_pct <= 50; end
            default: begin
               e = 8'h08; k = tle_pkg::CODE_WERASE; idle_pct = 27; stall_pct <= 27;
            end
         endcase
         set_codes(e, k);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS || (phase == 0 && !held)
                || (phase == 2 && !paused)) begin
            if (phase == 0 && !held && items_sent - phase_start >= HOLD_AFTER) begin
               hold_toggle <= ~hold_toggle;
               held = 1'b1;
            end
            if (phase == 2 && !paused && items_sent - phase_start >= PAUSE_AFTER) begin
               wait_for_display();
               paused = 1'b1;
            end
            send_token();
         end
      end

      wait_for_display();
      idle_pct = 0;
      stall_pct <= 0;
      set_codes(tle_pkg::ERASE_CHAR_RESET, tle_pkg::KILL_CHAR_RESET);
      send_byte(tle_pkg::CODE_NL);
      send_byte(tle_pkg::CODE_EOT);
      send_byte(tle_pkg::CODE_EOT);
      send_byte(8'h61);
      send_byte(tle_pkg::CODE_NL);
      send_byte(8'hFF);
      wait_for_display();

      if (fault_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
